// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the texture sampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BTS_ASSERT_IMPL(lbl, ante, cons)
`define BTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/bts_pkg.sv =====
// Types, constants and helpers of the bilinear texture sampler.
package bts_pkg;
  localparam int COL_BITS  = 9;
  localparam int ROW_BITS  = 8;
  localparam int CH_BITS   = 16;
  localparam int ADDR_BITS = COL_BITS + ROW_BITS;
  localparam int MAX_COLS  = 512;
  localparam int MAX_ROWS  = 256;
  localparam int W_BITS    = 10;
  localparam int H_BITS    = 9;

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CH_BITS-1:0] blue;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] red;
  } texel_t;

  // fetch addresses and fractions of one sample
  typedef struct packed {
    logic [COL_BITS-1:0] c0;
    logic [COL_BITS-1:0] c1;
    logic [ROW_BITS-1:0] r0;
    logic [ROW_BITS-1:0] r1;
    logic [15:0]         fx;
    logic [15:0]         fy;
  } fetch_t;

  // a + floor(f*(b-a)/65536), same as the weighted sum form
  function automatic logic [CH_BITS-1:0] lerp(input logic [CH_BITS-1:0] a,
                                              input logic [CH_BITS-1:0] b,
                                              input logic [15:0] f);
    logic signed [CH_BITS:0]    d;
    logic signed [CH_BITS+17:0] p;
    logic signed [CH_BITS+1:0]  s;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, f});
    s = $signed({2'b00, a}) + $signed(p[CH_BITS+17:16]);
    return s[CH_BITS-1:0];
  endfunction
endpackage

// ===== hw/rtl/bts_coord.sv =====
// Coordinate stages: scale by image size, split, wrap columns, clamp rows.
module bts_coord (
  input  logic                        clk,
  input  logic                        en,
  input  logic [15:0]                 coord_u,
  input  logic [15:0]                 coord_v,
  input  logic [bts_pkg::W_BITS-1:0]  tex_w,
  input  logic [bts_pkg::H_BITS-1:0]  tex_h,
  output bts_pkg::fetch_t             fetch
);
  logic signed [26:0] px_r;
  logic signed [24:0] py_r;
  logic [bts_pkg::W_BITS-1:0] w_r;
  logic [bts_pkg::H_BITS-1:0] h_r;
  bts_pkg::fetch_t fetch_r, fetch_nxt;
  logic [bts_pkg::W_BITS-1:0] x0, x1;
  logic [bts_pkg::H_BITS-1:0] y0, y1;

  // stage 1: p = coord*dim - 0.5, products kept at full width
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= $signed({1'b0, 26'(coord_u) * 26'(tex_w)}) - 27'sd32768;
      py_r <= $signed({1'b0, 24'(coord_v) * 24'(tex_h)}) - 25'sd32768;
      w_r  <= tex_w;
      h_r  <= tex_h;
    end
  end

  // stage 2: floor split, column wrap, row clamp
  always_comb begin
    x0 = {1'b0, px_r[24:16]};
    x1 = x0 + 10'd1;
    y0 = {1'b0, py_r[23:16]};
    y1 = y0 + 9'd1;
    fetch_nxt.fx = px_r[15:0];
    fetch_nxt.fy = py_r[15:0];
    if (px_r[26]) begin
      fetch_nxt.c0 = 9'(w_r - 10'd1);
      fetch_nxt.c1 = '0;
    end else begin
      fetch_nxt.c0 = x0[8:0];
      fetch_nxt.c1 = (x1 >= w_r) ? '0 : x1[8:0];
    end
    if (py_r[24]) begin
      fetch_nxt.r0 = '0;
      fetch_nxt.r1 = '0;
    end else begin
      fetch_nxt.r0 = y0[7:0];
      fetch_nxt.r1 = (y1 >= h_r) ? 8'(h_r - 9'd1) : y1[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) fetch_r <= fetch_nxt;
  end

  assign fetch = fetch_r;
endmodule

// ===== hw/rtl/bts_store.sv =====
// Texel store: two identical copies, each with one write and two read ports.
module bts_store (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          we,
  input  logic [bts_pkg::ADDR_BITS-1:0] waddr,
  input  bts_pkg::texel_t               wdata,
  input  bts_pkg::fetch_t               fetch,
  output bts_pkg::texel_t               t00,
  output bts_pkg::texel_t               t01,
  output bts_pkg::texel_t               t10,
  output bts_pkg::texel_t               t11
);
  bts_pkg::texel_t mem_top [0:(1<<bts_pkg::ADDR_BITS)-1];
  bts_pkg::texel_t mem_bot [0:(1<<bts_pkg::ADDR_BITS)-1];
  bts_pkg::texel_t t00_r, t01_r, t10_r, t11_r;

  // writes and reads run in item order at the same stage
  always_ff @(posedge clk) begin
    if (en && we) begin
      mem_top[waddr] <= wdata;
      mem_bot[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t00_r <= mem_top[{fetch.r0, fetch.c0}];
      t01_r <= mem_top[{fetch.r0, fetch.c1}];
      t10_r <= mem_bot[{fetch.r1, fetch.c0}];
      t11_r <= mem_bot[{fetch.r1, fetch.c1}];
    end
  end

  assign t00 = t00_r;
  assign t01 = t01_r;
  assign t10 = t10_r;
  assign t11 = t11_r;
endmodule

// ===== hw/rtl/bts_blend.sv =====
// Blend stages: horizontal lerp of both rows, then vertical lerp.
module bts_blend (
  input  logic            clk,
  input  logic            en,
  input  bts_pkg::texel_t t00,
  input  bts_pkg::texel_t t01,
  input  bts_pkg::texel_t t10,
  input  bts_pkg::texel_t t11,
  input  logic [15:0]     fx,
  input  logic [15:0]     fy,
  output bts_pkg::texel_t result
);
  bts_pkg::texel_t top_r, bot_r, res_r;
  logic [15:0] fy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      top_r.red   <= bts_pkg::lerp(t00.red,   t01.red,   fx);
      top_r.green <= bts_pkg::lerp(t00.green, t01.green, fx);
      top_r.blue  <= bts_pkg::lerp(t00.blue,  t01.blue,  fx);
      bot_r.red   <= bts_pkg::lerp(t10.red,   t11.red,   fx);
      bot_r.green <= bts_pkg::lerp(t10.green, t11.green, fx);
      bot_r.blue  <= bts_pkg::lerp(t10.blue,  t11.blue,  fx);
      fy_r        <= fy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.red   <= bts_pkg::lerp(top_r.red,   bot_r.red,   fy_r);
      res_r.green <= bts_pkg::lerp(top_r.green, bot_r.green, fy_r);
      res_r.blue  <= bts_pkg::lerp(top_r.blue,  bot_r.blue,  fy_r);
    end
  end

  assign result = res_r;
endmodule

// ===== hw/rtl/bilinear_texture_sampler_wrap_clamp_top.sv =====
// Top level of the bilinear texture sampler with column wrap and row clamp.
//
//  port group | dir | beat carries
//  in_*       | in  | texel write or sample request
//  out_*      | out | blended RGB of one sample
//  cfg_*      | in  | tex_width / tex_height writes
//
// One beat per cycle while the pipeline is not held; once its beat is taken, a sample
// result passes scale, split, store read, two lerp stages and the output register.
// Texel writes reach the store at the read stage, so accesses keep item order.
// Writes produce no result beat. A skid register behind the output register
// keeps the input open while one result waits; the pipeline holds when it fills.
// Reset clears valid bits and sets width 512, height 256; store contents are
// undefined until written.
`include "assert_macros.svh"
module bilinear_texture_sampler_wrap_clamp_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [103:0]  in_tdata,  // texel_col, texel_row, texel_red, texel_green,
                                   // texel_blue, coord_u, coord_v, zero fill
  input  logic          in_tuser,  // command
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [47:0]   out_tdata, // out_red, out_green, out_blue
  input  logic          cfg_we,
  input  logic          cfg_addr,
  input  logic [9:0]    cfg_wdata
);
  logic [bts_pkg::W_BITS-1:0] tex_w_r;
  logic [bts_pkg::H_BITS-1:0] tex_h_r;
  logic en;
  logic [5:1] vld_r;
  logic [3:1] cmd_r;
  logic [bts_pkg::ADDR_BITS-1:0] wa1_r, wa2_r;
  bts_pkg::texel_t wd1_r, wd2_r, in_tex, result;
  bts_pkg::fetch_t fetch;
  bts_pkg::texel_t t00, t01, t10, t11;
  logic [15:0] fx3_r, fy3_r;
  logic out_vld_r, skid_vld_r;
  bts_pkg::texel_t out_r, skid_r;

  // configuration, stored already limited to 1..max
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r <= 10'(bts_pkg::MAX_COLS);
      tex_h_r <= 9'(bts_pkg::MAX_ROWS);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bts_pkg::REG_WIDTH:
          tex_w_r <= (cfg_wdata == '0) ? 10'd1 :
                     (cfg_wdata > 10'(bts_pkg::MAX_COLS)) ? 10'(bts_pkg::MAX_COLS) :
                     cfg_wdata;
        bts_pkg::REG_HEIGHT:
          tex_h_r <= (cfg_wdata[8:0] == '0) ? 9'd1 :
                     (cfg_wdata[8:0] > 9'(bts_pkg::MAX_ROWS)) ? 9'(bts_pkg::MAX_ROWS) :
                     cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign en        = !skid_vld_r;
  assign in_tready = en;
  assign in_tex    = '{blue: in_tdata[64:49], green: in_tdata[48:33], red: in_tdata[32:17]};

  // valid and command bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:3], vld_r[2] && cmd_r[2] == bts_pkg::CMD_SAMPLE, vld_r[1],
                in_tvalid};
    end
  end

  // write payload follows the coordinate stages
  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r <= {cmd_r[2:1], in_tuser};
      wa1_r <= {in_tdata[16:9], in_tdata[8:0]};
      wd1_r <= in_tex;
      wa2_r <= wa1_r;
      wd2_r <= wd1_r;
      fx3_r <= fetch.fx;
      fy3_r <= fetch.fy;
    end
  end

  bts_coord u_coord (
    .clk     (clk),
    .en      (en),
    .coord_u (in_tdata[80:65]),
    .coord_v (in_tdata[96:81]),
    .tex_w   (tex_w_r),
    .tex_h   (tex_h_r),
    .fetch   (fetch)
  );

  bts_store u_store (
    .clk   (clk),
    .en    (en),
    .we    (vld_r[2] && cmd_r[2] == bts_pkg::CMD_WRITE),
    .waddr (wa2_r),
    .wdata (wd2_r),
    .fetch (fetch),
    .t00   (t00),
    .t01   (t01),
    .t10   (t10),
    .t11   (t11)
  );

  bts_blend u_blend (
    .clk    (clk),
    .en     (en),
    .t00    (t00),
    .t01    (t01),
    .t10    (t10),
    .t11    (t11),
    .fx     (fx3_r),
    .fy     (fy3_r),
    .result (result)
  );

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) skid_vld_r <= 1'b0;
    end else if (vld_r[5]) begin
      if (out_vld_r && !out_tready) skid_vld_r <= 1'b1;
      else out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_tready) out_r <= skid_r;
    end else if (vld_r[5]) begin
      if (out_vld_r && !out_tready) skid_r <= result;
      else out_r <= result;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.blue, out_r.green, out_r.red};

  `BTS_ASSERT_IMPL(a_skid_behind_out, skid_vld_r, out_vld_r)
  `BTS_ASSERT_NEXT(a_skid_drains, skid_vld_r && out_tready, !skid_vld_r && out_vld_r)
  `BTS_ASSERT_NEXT(a_hold_when_full, skid_vld_r && !out_tready, skid_vld_r)
endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the bilinear texture sampler with column wrap and row clamp.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic        cmd;
    logic [8:0]  col;
    logic [7:0]  row;
    logic [15:0] red, green, blue;
    logic [15:0] u, v;
  } tex_req_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;  // texel_col, texel_row, red, green, blue, u, v, zero fill
  logic         in_tuser = 1'b0;  // command
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;  // out_red, out_green, out_blue
  logic         cfg_we = 1'b0;
  logic         cfg_addr = 1'b0;
  logic [9:0]   cfg_wdata = '0;

  // predictor state
  bts_pkg::texel_t tex_mem [bts_pkg::MAX_COLS*bts_pkg::MAX_ROWS];
  bit              tex_written [bts_pkg::MAX_COLS*bts_pkg::MAX_ROWS];
  logic [9:0]      width_q;
  logic [8:0]      height_q;
  bts_pkg::texel_t pixel_q[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  int sent_cnt = 0;

  bilinear_texture_sampler_wrap_clamp_top u_dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    bts_pkg::texel_t exp_px, got_px;
    if (rst_n && out_tvalid && out_tready) begin
      got_px = bts_pkg::texel_t'(out_tdata);
      if (pixel_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        exp_px = pixel_q.pop_front();
        if (got_px.red !== exp_px.red || got_px.green !== exp_px.green ||
            got_px.blue !== exp_px.blue) begin
          errors++;
          if (errors <= 10)
            $display("rgb mismatch: expected %h %h %h, got %h %h %h",
                     exp_px.red, exp_px.green, exp_px.blue,
                     got_px.red, got_px.green, got_px.blue);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic int eff_dim(int r, int maxv);
    if (r == 0) return 1;
    if (r > maxv) return maxv;
    return r;
  endfunction

  // coord*dim - 0.5 split into floor part and Q0.16 fraction
  function automatic void split_pos(int coord, int dim, output int ip, output int fr);
    longint p;
    p = longint'(coord) * dim - 32768;
    if (p < 0) begin
      ip = -1;
      fr = int'(p + 65536);
    end else begin
      ip = int'(p >> 16);
      fr = int'(p & 16'hFFFF);
    end
  endfunction

  // store addresses of the four neighbors: top-left, top-right, bottom-left, bottom-right
  function automatic void corners(logic [15:0] u, logic [15:0] v,
                                  output int addr[4], output int fx, output int fy);
    int w, h, x0, y0, c0, c1, r0, r1;
    w = eff_dim(width_q, bts_pkg::MAX_COLS);
    h = eff_dim(height_q, bts_pkg::MAX_ROWS);
    split_pos(u, w, x0, fx);
    split_pos(v, h, y0, fy);
    c0 = ((x0 % w) + w) % w;
    c1 = (((x0 + 1) % w) + w) % w;
    r0 = (y0 < 0) ? 0 : (y0 >= h) ? h - 1 : y0;
    r1 = (y0 + 1 >= h) ? h - 1 : y0 + 1;
    addr[0] = r0 * bts_pkg::MAX_COLS + c0;
    addr[1] = r0 * bts_pkg::MAX_COLS + c1;
    addr[2] = r1 * bts_pkg::MAX_COLS + c0;
    addr[3] = r1 * bts_pkg::MAX_COLS + c1;
  endfunction

  function automatic longint blend_q16(longint a, longint b, int f);
    return ((65536 - f) * a + longint'(f) * b) >> 16;
  endfunction

  function automatic bts_pkg::texel_t sample_pixel(logic [15:0] u, logic [15:0] v);
    int a[4];
    int fx, fy;
    bts_pkg::texel_t t[4];
    bts_pkg::texel_t px;
    corners(u, v, a, fx, fy);
    foreach (t[i]) t[i] = tex_mem[a[i]];
    px.red   = 16'(blend_q16(blend_q16(t[0].red, t[1].red, fx),
                             blend_q16(t[2].red, t[3].red, fx), fy));
    px.green = 16'(blend_q16(blend_q16(t[0].green, t[1].green, fx),
                             blend_q16(t[2].green, t[3].green, fx), fy));
    px.blue  = 16'(blend_q16(blend_q16(t[0].blue, t[1].blue, fx),
                             blend_q16(t[2].blue, t[3].blue, fx), fy));
    return px;
  endfunction

  // drive one beat, update the predictor on acceptance, then maybe idle
  task automatic send_beat(tex_req_t rq);
    int gap;
    int a;
    gap = 0;
    in_tvalid <= 1'b1;
    in_tuser  <= rq.cmd;
    in_tdata  <= {7'b0, rq.v, rq.u, rq.blue, rq.green, rq.red, rq.row, rq.col};
    do @(posedge clk); while (!in_tready);
    sent_cnt++;
    if (rq.cmd == bts_pkg::CMD_WRITE) begin
      a = rq.row * bts_pkg::MAX_COLS + rq.col;
      tex_mem[a] = '{blue: rq.blue, green: rq.green, red: rq.red};
      tex_written[a] = 1'b1;
    end else begin
      pixel_q = {pixel_q, sample_pixel(rq.u, rq.v)};
    end
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic tex_req_t rand_req(logic cmd);
    tex_req_t rq;
    rq.cmd = cmd;
    rq.col = 9'($urandom_range(511));
    rq.row = 8'($urandom_range(255));
    rq.red = 16'($urandom);
    rq.green = 16'($urandom);
    rq.blue = 16'($urandom);
    rq.u = 16'($urandom);
    rq.v = 16'($urandom);
    return rq;
  endfunction

  task automatic write_texel(int col, int row, logic [15:0] r, logic [15:0] g,
                             logic [15:0] b);
    tex_req_t rq;
    rq = rand_req(bts_pkg::CMD_WRITE);
    rq.col = 9'(col);
    rq.row = 8'(row);
    rq.red = r;
    rq.green = g;
    rq.blue = b;
    send_beat(rq);
  endtask

  // sample, first filling any neighbor texel never written
  task automatic sample_at(logic [15:0] u, logic [15:0] v);
    int a[4];
    int fx, fy;
    tex_req_t rq;
    corners(u, v, a, fx, fy);
    foreach (a[i])
      if (!tex_written[a[i]])
        write_texel(a[i] % bts_pkg::MAX_COLS, a[i] / bts_pkg::MAX_COLS,
                    16'($urandom), 16'($urandom), 16'($urandom));
    rq = rand_req(bts_pkg::CMD_SAMPLE);
    rq.u = u;
    rq.v = v;
    send_beat(rq);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [9:0] val);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bts_pkg::REG_WIDTH) width_q = val;
    else height_q = val[8:0];
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // extremes of values and coordinates, wrap and clamp at the borders
  task automatic test_directed();
    write_reg(bts_pkg::REG_WIDTH, 10'd4);
    write_reg(bts_pkg::REG_HEIGHT, 10'd3);
    write_texel(0, 0, 16'hFFFF, 16'h0000, 16'hFFFF);
    write_texel(3, 0, 16'h0000, 16'hFFFF, 16'h0000);
    write_texel(0, 2, 16'hFFFF, 16'hFFFF, 16'h0000);
    write_texel(3, 2, 16'h0000, 16'h0000, 16'hFFFF);
    write_texel(511, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    sample_at(16'h0000, 16'h0000);
    sample_at(16'hFFFF, 16'hFFFF);
    sample_at(16'h8000, 16'h8000);
    sample_at(16'h0000, 16'hFFFF);
    sample_at(16'hFFFF, 16'h0000);
    // zero dimensions act as one
    write_reg(bts_pkg::REG_WIDTH, 10'd0);
    write_reg(bts_pkg::REG_HEIGHT, 10'd0);
    sample_at(16'h1234, 16'hFFFF);
    sample_at(16'h0000, 16'h0000);
    // oversized dimensions saturate
    write_reg(bts_pkg::REG_WIDTH, 10'h3FF);
    write_reg(bts_pkg::REG_HEIGHT, 10'h3FF);
    sample_at(16'hFFFF, 16'hFFFF);
    sample_at(16'h0000, 16'h0000);
  endtask

  // at least n beats in total, texel fills included
  task automatic random_phase(int n, int idle_pct, int stall_pct);
    int w, h, stop;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    case ($urandom_range(3))
      0: begin w = 512; h = 256; end
      1: begin w = $urandom_range(1023); h = $urandom_range(511); end
      default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 12); end
    endcase
    write_reg(bts_pkg::REG_WIDTH, 10'(w));
    write_reg(bts_pkg::REG_HEIGHT, 10'(h));
    stop = sent_cnt + n;
    while (sent_cnt < stop) begin
      if ($urandom_range(3) == 0) send_beat(rand_req(bts_pkg::CMD_WRITE));
      else sample_at(pick_coord(), pick_coord());
    end
    wait_drain();
  endtask

  // receiver holds off while samples keep coming, then sender waits for all results
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(bts_pkg::REG_WIDTH, 10'd8);
    write_reg(bts_pkg::REG_HEIGHT, 10'd8);
    repeat (4) sample_at(pick_coord(), pick_coord());
    wait_drain();
    hold_cycles = 300;
    repeat (40) sample_at(pick_coord(), pick_coord());
    wait_drain();
  endtask

  initial begin
    width_q = 10'd512;
    height_q = 9'd256;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    random_phase(500, 0, 0);
    random_phase(400, 70, 0);
    random_phase(400, 0, 70);
    random_phase(400, 7, 7);
    random_phase(300, 0, 0);
    test_backpressure();
    wait_drain();
    repeat (20) @(posedge clk);
    if (pixel_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
